// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for concurrent assertions clocked by clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== rtl/core/lmmat_pkg.sv =====
// ----------------------------------------------------------------------------
// lmmat_pkg
// Types and constants shared by the latency statistics table files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lmmat_pkg;

  localparam int NumClasses = 512;
  localparam int AddrW      = $clog2(NumClasses);
  localparam int ClsW       = 9;
  localparam int DataW      = 64;
  localparam int HalfW      = DataW / 2;
  localparam int CntW       = $clog2(DataW);

  typedef struct packed {
    logic [ClsW-1:0]  event_class;
    logic [DataW-1:0] start_time;
    logic [DataW-1:0] end_time;
    logic             timeable;
  } lmmat_in_item_t;

  typedef struct packed {
    logic             counted;
    logic [DataW-1:0] class_minimum;
    logic [DataW-1:0] class_maximum;
    logic [DataW-1:0] class_average;
    logic [DataW-1:0] class_count;
    logic [DataW-1:0] overall_minimum;
    logic [DataW-1:0] overall_maximum;
    logic [DataW-1:0] overall_average;
    logic [DataW-1:0] overall_count;
  } lmmat_out_item_t;

  // One statistics record, as stored in the class table.
  typedef struct packed {
    logic [DataW-1:0] minimum;
    logic [DataW-1:0] maximum;
    logic [DataW-1:0] average;
    logic [DataW-1:0] count;
  } lmmat_stat_t;

  localparam int StatW = $bits(lmmat_stat_t);

  localparam lmmat_stat_t StatReset = '{
    minimum: {DataW{1'b1}},
    maximum: {DataW{1'b0}},
    average: {DataW{1'b0}},
    count:   {DataW{1'b0}}
  };

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_DIVGO,
    ST_DIV,
    ST_DONE
  } lmmat_state_e;

endpackage

`default_nettype wire

// ===== rtl/core/lmmat_if.sv =====
// ----------------------------------------------------------------------------
// lmmat_in_if / lmmat_out_if
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lmmat_in_if;
  import lmmat_pkg::*;

  logic           valid;
  logic           ready;
  lmmat_in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lmmat_out_if;
  import lmmat_pkg::*;

  logic            valid;
  logic            ready;
  lmmat_out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lmmat_ram.sv =====
// ----------------------------------------------------------------------------
// lmmat_ram
// Generic single-write, single-read synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lmmat_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/lmmat_div.sv =====
// ----------------------------------------------------------------------------
// lmmat_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lmmat_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [lmmat_pkg::DataW-1:0] dividend_i,
  input  wire logic [lmmat_pkg::DataW-1:0] divisor_i,
  output      logic                        busy_o,
  output      logic [lmmat_pkg::DataW-1:0] quotient_o
);
  import lmmat_pkg::*;

  logic             busy_q, busy_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [DataW-1:0] rem_q, rem_d;
  logic [DataW-1:0] quo_q, quo_d;
  logic [DataW-1:0] dsr_q, dsr_d;
  logic [DataW:0]   trial;
  logic [DataW:0]   diff;
  logic             fits;

  // The dividend shifts out of quo_q at the top while quotient bits enter at
  // the bottom. A zero divisor always fits, so its quotient is all ones.
  always_comb begin
    trial  = {rem_q, quo_q[DataW-1]};
    diff   = trial - {1'b0, dsr_q};
    fits   = trial >= {1'b0, dsr_q};
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? diff[DataW-1:0] : trial[DataW-1:0];
      quo_d = {quo_q[DataW-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == {CntW{1'b1}}) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// ===== rtl/core/latency_min_max_average_table_unit.sv =====
// ----------------------------------------------------------------------------
// latency_min_max_average_table_unit
// Per-class and overall minimum, maximum, rolling average and count of
// event latencies.
// ----------------------------------------------------------------------------
// Usage: every item on in_i carries an event class, a start and an end
// timestamp and a timeable flag. The elapsed time is end minus start, modulo
// 2^64. A timeable item of a class in range folds that sample into the class
// record and the overall record; every item returns one result item on out_o
// with the class and overall statistics after the update.
// Flow: a counted item goes from acceptance through a table read, the multiply
// steps on the shared 32x32 multiplier, a divider start step, the bit-serial
// dividers, and write-back with the result load into the output register. An
// item that is not counted goes from the table read straight to the output
// register. One item is in work at a time, and the divider loop sets how long
// a counted item occupies the block.
// Reset: the class table lives in one RAM. After reset the block sweeps all
// 512 entries, one per cycle, to their reset values; in_i.ready stays low
// until the sweep ends. The overall record resets at once.
// Stalls: the result sits in an output register, so the next item is taken
// and worked on while out_o is stalled; it then waits at write-back until
// the register frees up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module latency_min_max_average_table_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  lmmat_in_if.sink    in_i,
  lmmat_out_if.source out_o
);
  import lmmat_pkg::*;

  localparam int CmpW = ((AddrW > ClsW) ? AddrW : ClsW) + 1;

  // Control state.
  lmmat_state_e    state_q, state_d;
  logic [AddrW-1:0] clr_q, clr_d;
  logic [2:0]       mstep_q, mstep_d;
  logic             out_valid_q, out_valid_d;

  // Overall record.
  logic [DataW-1:0] tot_min_q, tot_min_d;
  logic [DataW-1:0] tot_max_q, tot_max_d;
  logic [DataW-1:0] tot_avg_q, tot_avg_d;
  logic [DataW-1:0] tot_cnt_q, tot_cnt_d;

  // Item in work.
  logic [AddrW-1:0] cls_q, cls_d;
  logic             in_range_q, in_range_d;
  logic             counted_q, counted_d;
  logic [DataW-1:0] elapsed_q, elapsed_d;
  logic [DataW-1:0] prod_q, prod_d;
  logic [DataW-1:0] cls_acc_q, cls_acc_d;
  logic [DataW-1:0] tot_acc_q, tot_acc_d;
  lmmat_out_item_t  out_data_q, out_data_d;

  logic             in_fire;
  logic             out_free;
  logic             done_fire;
  logic             in_range_in;
  logic [HalfW-1:0] mul_a, mul_b;

  // Table RAM.
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  lmmat_stat_t      ram_wdata;
  logic             ram_re;
  logic [AddrW-1:0] ram_raddr;
  lmmat_stat_t      entry;

  // Dividers, one for the class record and one for the overall record.
  logic             div_start;
  logic             cls_busy, tot_busy;
  logic [DataW-1:0] cls_quo, tot_quo;
  logic [DataW-1:0] cls_inc, tot_inc;

  lmmat_stat_t      cls_new;
  lmmat_stat_t      tot_new;

  lmmat_ram #(
    .Width(StatW),
    .Depth(NumClasses)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(entry)
  );

  lmmat_div u_cls_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(cls_acc_q),
    .divisor_i (cls_inc),
    .busy_o    (cls_busy),
    .quotient_o(cls_quo)
  );

  lmmat_div u_tot_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(tot_acc_q),
    .divisor_i (tot_inc),
    .busy_o    (tot_busy),
    .quotient_o(tot_quo)
  );

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign done_fire  = (state_q == ST_DONE) && out_free;
  assign div_start  = (state_q == ST_DIVGO);

  assign in_range_in = CmpW'(in_i.data.event_class) < CmpW'(NumClasses);

  // The divisor is count + 1 and wraps to zero at the limit.
  assign cls_inc = entry.count + 1'b1;
  assign tot_inc = tot_cnt_q + 1'b1;

  // The table read holds its data until the next accepted item, so the
  // entry stays valid at the RAM output for the whole update.
  assign ram_re    = in_fire;
  assign ram_raddr = AddrW'(in_i.data.event_class);

  // The product of the two 32-bit multiplier operands is registered before
  // it is added into an accumulator.
  assign prod_d = DataW'(mul_a) * DataW'(mul_b);

  always_comb begin
    cls_new.minimum = (elapsed_q < entry.minimum) ? elapsed_q : entry.minimum;
    cls_new.maximum = (elapsed_q > entry.maximum) ? elapsed_q : entry.maximum;
    cls_new.average = cls_quo;
    cls_new.count   = cls_inc;
    tot_new.minimum = (elapsed_q < tot_min_q) ? elapsed_q : tot_min_q;
    tot_new.maximum = (elapsed_q > tot_max_q) ? elapsed_q : tot_max_q;
    tot_new.average = tot_quo;
    tot_new.count   = tot_inc;
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    mstep_d     = '0;
    out_valid_d = out_valid_q;
    tot_min_d   = tot_min_q;
    tot_max_d   = tot_max_q;
    tot_avg_d   = tot_avg_q;
    tot_cnt_d   = tot_cnt_q;
    cls_d       = cls_q;
    in_range_d  = in_range_q;
    counted_d   = counted_q;
    elapsed_d   = elapsed_q;
    cls_acc_d   = cls_acc_q;
    tot_acc_d   = tot_acc_q;
    out_data_d  = out_data_q;
    mul_a       = '0;
    mul_b       = '0;
    ram_we      = 1'b0;
    ram_waddr   = cls_q;
    ram_wdata   = cls_new;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = StatReset;
        clr_d     = clr_q + 1'b1;
        if (clr_q == AddrW'(NumClasses - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          cls_d      = AddrW'(in_i.data.event_class);
          in_range_d = in_range_in;
          counted_d  = in_i.data.timeable && in_range_in;
          elapsed_d  = in_i.data.end_time - in_i.data.start_time;
          state_d    = ST_READ;
        end
      end
      ST_READ: begin
        // Each dividend starts as the sample; the product is added onto it.
        cls_acc_d = elapsed_q;
        tot_acc_d = elapsed_q;
        state_d   = counted_q ? ST_MUL : ST_DONE;
      end
      ST_MUL: begin
        // Low 64 bits of count * average from three 32x32 partial products:
        // low by low, then the two cross terms shifted up by 32. The add of
        // each product comes in the cycle after its multiply.
        mstep_d = mstep_q + 1'b1;
        case (mstep_q)
          3'd0: begin
            mul_a = entry.count[HalfW-1:0];
            mul_b = entry.average[HalfW-1:0];
          end
          3'd1: begin
            mul_a     = entry.count[HalfW-1:0];
            mul_b     = entry.average[DataW-1:HalfW];
            cls_acc_d = cls_acc_q + prod_q;
          end
          3'd2: begin
            mul_a     = entry.count[DataW-1:HalfW];
            mul_b     = entry.average[HalfW-1:0];
            cls_acc_d = cls_acc_q + {prod_q[HalfW-1:0], {HalfW{1'b0}}};
          end
          3'd3: begin
            mul_a     = tot_cnt_q[HalfW-1:0];
            mul_b     = tot_avg_q[HalfW-1:0];
            cls_acc_d = cls_acc_q + {prod_q[HalfW-1:0], {HalfW{1'b0}}};
          end
          3'd4: begin
            mul_a     = tot_cnt_q[HalfW-1:0];
            mul_b     = tot_avg_q[DataW-1:HalfW];
            tot_acc_d = tot_acc_q + prod_q;
          end
          3'd5: begin
            mul_a     = tot_cnt_q[DataW-1:HalfW];
            mul_b     = tot_avg_q[HalfW-1:0];
            tot_acc_d = tot_acc_q + {prod_q[HalfW-1:0], {HalfW{1'b0}}};
          end
          3'd6: begin
            tot_acc_d = tot_acc_q + {prod_q[HalfW-1:0], {HalfW{1'b0}}};
            state_d   = ST_DIVGO;
          end
          default: begin
            state_d = ST_DIVGO;
          end
        endcase
      end
      ST_DIVGO: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (!cls_busy && !tot_busy) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // Write-back of a counted item and the result load happen together, once,
        // when the output register is free.
        if (done_fire) begin
          out_valid_d        = 1'b1;
          out_data_d.counted = counted_q;
          if (counted_q) begin
            ram_we                     = 1'b1;
            tot_min_d                  = tot_new.minimum;
            tot_max_d                  = tot_new.maximum;
            tot_avg_d                  = tot_new.average;
            tot_cnt_d                  = tot_new.count;
            out_data_d.class_minimum   = cls_new.minimum;
            out_data_d.class_maximum   = cls_new.maximum;
            out_data_d.class_average   = cls_new.average;
            out_data_d.class_count     = cls_new.count;
            out_data_d.overall_minimum = tot_new.minimum;
            out_data_d.overall_maximum = tot_new.maximum;
            out_data_d.overall_average = tot_new.average;
            out_data_d.overall_count   = tot_new.count;
          end else begin
            out_data_d.class_minimum   = in_range_q ? entry.minimum : '0;
            out_data_d.class_maximum   = in_range_q ? entry.maximum : '0;
            out_data_d.class_average   = in_range_q ? entry.average : '0;
            out_data_d.class_count     = in_range_q ? entry.count : '0;
            out_data_d.overall_minimum = tot_min_q;
            out_data_d.overall_maximum = tot_max_q;
            out_data_d.overall_average = tot_avg_q;
            out_data_d.overall_count   = tot_cnt_q;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      mstep_q     <= '0;
      out_valid_q <= 1'b0;
      tot_min_q   <= {DataW{1'b1}};
      tot_max_q   <= '0;
      tot_avg_q   <= '0;
      tot_cnt_q   <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      mstep_q     <= mstep_d;
      out_valid_q <= out_valid_d;
      tot_min_q   <= tot_min_d;
      tot_max_q   <= tot_max_d;
      tot_avg_q   <= tot_avg_d;
      tot_cnt_q   <= tot_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cls_q      <= cls_d;
    in_range_q <= in_range_d;
    counted_q  <= counted_d;
    elapsed_q  <= elapsed_d;
    prod_q     <= prod_d;
    cls_acc_q  <= cls_acc_d;
    tot_acc_q  <= tot_acc_d;
    out_data_q <= out_data_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // The table is never written in the cycle that a new item reads it.
  `ASSERT_NEVER(a_no_rw_overlap, ram_we && ram_re, "table write overlaps an item read")

  // Both dividers start together and must finish together.
  `ASSERT_CLK(a_div_lockstep, cls_busy == tot_busy, "dividers out of step")

  // The overall count moves only when a counted item is written back.
  `ASSERT_CLK(a_tot_cnt_update, (tot_cnt_q != $past(tot_cnt_q)) |->
    $past(done_fire && counted_q), "overall count changed without a counted item")

endmodule

`default_nettype wire

// ===== tb/sv/latency_min_max_average_table_unit_tb.sv =====
// ----------------------------------------------------------------------------
// latency_min_max_average_table_unit_tb
// Self-checking bench for the latency statistics table: directed rows and
// constrained-by-hand random events, scored against a local statistics model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module latency_min_max_average_table_unit_tb;
  import lmmat_pkg::*;

  // Timing of the run. About 1650 items plus the table sweep after reset
  // must finish within the cycle limit; the limit leaves plenty of room for
  // stalls.
  localparam int CycleLimit  = 1_000_000;
  localparam int DrainCycles = 100;
  localparam int RandomItems = 1630;
  localparam int NumDirected = 16;

  // Random items in this window run with both sides never idling.
  localparam int SteadyFirst = 500;
  localparam int SteadyLast  = 800;

  localparam logic [DataW-1:0] AllOnes  = {DataW{1'b1}};
  localparam logic [DataW-1:0] MsbOnly  = {1'b1, {(DataW-1){1'b0}}};
  localparam logic [DataW-1:0] HalfDown = {1'b0, {(DataW-1){1'b1}}};

  // One row of the directed table. When has_result is set, the result is
  // known by inspection and is checked as written; otherwise the local
  // statistics model supplies it.
  typedef struct packed {
    lmmat_in_item_t  stim;
    logic            has_result;
    lmmat_out_item_t result;
  } event_row_t;

  logic clk_i;
  logic rst_ni;

  lmmat_in_if  in_bus ();
  lmmat_out_if out_bus ();

  latency_min_max_average_table_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  // Local copy of the statistics: one record per class and one overall.
  lmmat_stat_t class_stats [NumClasses];
  lmmat_stat_t overall_stats;

  // Results owed by the block, oldest first.
  lmmat_out_item_t pending_results [$];
  lmmat_out_item_t want;

  int unsigned cycle_count    = 0;
  int unsigned mismatch_count = 0;
  int unsigned items_sent     = 0;
  int unsigned events_counted = 0;
  int unsigned results_seen   = 0;
  bit          steady         = 1'b0;

  // The directed table. The first five rows walk from reset through the
  // corners that are easy to work out by hand: an untimeable event on an
  // empty class, the largest elapsed time, an end stamp below the start
  // stamp (elapsed wraps to one, and the overall sum wraps to zero), a zero
  // elapsed time, and an untimeable event that must leave a class untouched.
  event_row_t directed_rows [NumDirected] = '{
    '{'{9'd5, 64'd0, 64'd0, 1'b0}, 1'b1,
      '{1'b0, AllOnes, 64'd0, 64'd0, 64'd0, AllOnes, 64'd0, 64'd0, 64'd0}},
    '{'{9'd0, 64'd0, AllOnes, 1'b1}, 1'b1,
      '{1'b1, AllOnes, AllOnes, AllOnes, 64'd1, AllOnes, AllOnes, AllOnes, 64'd1}},
    '{'{9'd511, AllOnes, 64'd0, 1'b1}, 1'b1,
      '{1'b1, 64'd1, 64'd1, 64'd1, 64'd1, 64'd1, AllOnes, 64'd0, 64'd2}},
    '{'{9'd0, MsbOnly, MsbOnly, 1'b1}, 1'b1,
      '{1'b1, 64'd0, AllOnes, HalfDown, 64'd2, 64'd0, AllOnes, 64'd0, 64'd3}},
    '{'{9'd0, 64'd123, AllOnes, 1'b0}, 1'b1,
      '{1'b0, 64'd0, AllOnes, HalfDown, 64'd2, 64'd0, AllOnes, 64'd0, 64'd3}},
    // Alternating bit patterns on the stamps, both directions, and on the class.
    '{'{9'd256, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b1}, 1'b0, '0},
    '{'{9'h155, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1}, 1'b0, '0},
    '{'{9'h0AA, 64'd0, 64'd1000, 1'b1}, 1'b0, '0},
    // Large samples on a class that already holds a large average, so the
    // count times average product plus the sample wraps.
    '{'{9'd0, 64'd0, 64'hFFFF_0000_0000_0000, 1'b1}, 1'b0, '0},
    '{'{9'd0, 64'h1000, 64'hC000_0000_0000_1000, 1'b1}, 1'b0, '0},
    // Small samples on one class; the last one straddles the wrap of time.
    '{'{9'd511, 64'd100, 64'd110, 1'b1}, 1'b0, '0},
    '{'{9'd511, 64'd5, 64'd35, 1'b1}, 1'b0, '0},
    '{'{9'd511, 64'hFFFF_FFFF_FFFF_FFF6, 64'd10, 1'b1}, 1'b0, '0},
    '{'{9'd7, AllOnes, AllOnes, 1'b0}, 1'b0, '0},
    '{'{9'd1, 64'd0, MsbOnly, 1'b1}, 1'b0, '0},
    '{'{9'd511, 64'd0, 64'd0, 1'b1}, 1'b0, '0}
  };

  // --------------------------------------------------------------------------
  // Clock and cycle limit
  // --------------------------------------------------------------------------
  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // A hung handshake ends the run here.
  initial begin
    wait (cycle_count == CycleLimit);
    $display("Timeout after %0d cycles with %0d results outstanding.",
             cycle_count, pending_results.size());
    $display("FAILED: results differ");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Statistics model
  // --------------------------------------------------------------------------

  // Folds one sample into a record. Product and sum wrap at 64 bits, and a
  // count that would wrap to zero forces the quotient to all ones, which is
  // what the hardware divider gives for a zero divisor.
  function automatic lmmat_stat_t fold_sample(lmmat_stat_t rec,
                                              logic [DataW-1:0] sample);
    logic [DataW-1:0] divisor;
    logic [DataW-1:0] dividend;
    divisor  = rec.count + 64'd1;
    dividend = rec.count * rec.average + sample;
    if (sample < rec.minimum) rec.minimum = sample;
    if (sample > rec.maximum) rec.maximum = sample;
    rec.average = (divisor == '0) ? AllOnes : dividend / divisor;
    rec.count   = divisor;
    return rec;
  endfunction

  // Applies one event to the local statistics and returns the result item
  // the block owes for it.
  function automatic lmmat_out_item_t update_latency_stats(lmmat_in_item_t ev);
    lmmat_out_item_t  res;
    logic [DataW-1:0] elapsed;
    bit               in_range;
    elapsed  = ev.end_time - ev.start_time;
    in_range = int'(ev.event_class) < NumClasses;
    res.counted = ev.timeable && in_range;
    if (res.counted) begin
      class_stats[ev.event_class] = fold_sample(class_stats[ev.event_class], elapsed);
      overall_stats               = fold_sample(overall_stats, elapsed);
      events_counted++;
    end
    // A class outside the table reports zeros; with 512 classes and a
    // 9-bit index this cannot happen, but the rule is kept in one place.
    if (in_range) begin
      res.class_minimum = class_stats[ev.event_class].minimum;
      res.class_maximum = class_stats[ev.event_class].maximum;
      res.class_average = class_stats[ev.event_class].average;
      res.class_count   = class_stats[ev.event_class].count;
    end else begin
      res.class_minimum = '0;
      res.class_maximum = '0;
      res.class_average = '0;
      res.class_count   = '0;
    end
    res.overall_minimum = overall_stats.minimum;
    res.overall_maximum = overall_stats.maximum;
    res.overall_average = overall_stats.average;
    res.overall_count   = overall_stats.count;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  // Presents one event and waits for the block to take it. On acceptance the
  // owed result is queued: the typed-in one for a directed row that has it,
  // the modeled one otherwise. The model is updated in both cases so that
  // later rows see the right state.
  task automatic send_event(input lmmat_in_item_t ev, input bit has_result,
                            input lmmat_out_item_t typed_result);
    lmmat_out_item_t modeled;
    // Random idle cycles ahead of the item, except in the steady stretch.
    while (!steady && $urandom_range(0, 99) < 10) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid <= 1'b1;
    in_bus.data  <= ev;
    do @(posedge clk_i); while (in_bus.ready !== 1'b1);
    modeled = update_latency_stats(ev);
    pending_results.push_back(has_result ? typed_result : modeled);
    items_sent++;
  endtask

  // Random events. Most land on a handful of classes so that counts and
  // averages grow deep; the spans mix short latencies, full-range values,
  // spans that put the end stamp below the start, and zero.
  function automatic lmmat_in_item_t random_event();
    lmmat_in_item_t   ev;
    logic [DataW-1:0] span;
    int unsigned      pick;
    if ($urandom_range(0, 99) < 70) ev.event_class = ClsW'($urandom_range(0, 7));
    else ev.event_class = ClsW'($urandom_range(0, NumClasses - 1));
    pick = $urandom_range(0, 99);
    if (pick < 5) ev.start_time = '0;
    else if (pick < 10) ev.start_time = AllOnes;
    else ev.start_time = {$urandom, $urandom};
    pick = $urandom_range(0, 99);
    if (pick < 45) span = 64'($urandom_range(0, 5000));
    else if (pick < 65) span = {$urandom, $urandom};
    else if (pick < 75) span = {32'hFFFF_FFFF, $urandom};
    else if (pick < 90) span = {$urandom, $urandom} >> $urandom_range(0, 63);
    else if (pick < 95) span = '0;
    else span = AllOnes;
    ev.end_time = ev.start_time + span;
    ev.timeable = $urandom_range(0, 99) < 85;
    return ev;
  endfunction

  // --------------------------------------------------------------------------
  // Output side
  // --------------------------------------------------------------------------

  // The receiver stalls about ten percent of the time, never in the steady stretch.
  always @(posedge clk_i) begin
    out_bus.ready <= steady || ($urandom_range(0, 99) >= 10);
  end

  task automatic report_mismatch(input string what, input logic [DataW-1:0] got,
                                 input logic [DataW-1:0] wanted);
    mismatch_count++;
    $display("%0t: %s mismatch, got %h, want %h", $realtime, what, got, wanted);
  endtask

  // Every accepted result is scored against the oldest owed result.
  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result item, overall_count",
                        out_bus.data.overall_count, '0);
      end else begin
        want = pending_results.pop_front();
        if (out_bus.data.counted !== want.counted)
          report_mismatch("counted", 64'(out_bus.data.counted), 64'(want.counted));
        if (out_bus.data.class_minimum !== want.class_minimum)
          report_mismatch("class_minimum", out_bus.data.class_minimum,
                          want.class_minimum);
        if (out_bus.data.class_maximum !== want.class_maximum)
          report_mismatch("class_maximum", out_bus.data.class_maximum,
                          want.class_maximum);
        if (out_bus.data.class_average !== want.class_average)
          report_mismatch("class_average", out_bus.data.class_average,
                          want.class_average);
        if (out_bus.data.class_count !== want.class_count)
          report_mismatch("class_count", out_bus.data.class_count, want.class_count);
        if (out_bus.data.overall_minimum !== want.overall_minimum)
          report_mismatch("overall_minimum", out_bus.data.overall_minimum,
                          want.overall_minimum);
        if (out_bus.data.overall_maximum !== want.overall_maximum)
          report_mismatch("overall_maximum", out_bus.data.overall_maximum,
                          want.overall_maximum);
        if (out_bus.data.overall_average !== want.overall_average)
          report_mismatch("overall_average", out_bus.data.overall_average,
                          want.overall_average);
        if (out_bus.data.overall_count !== want.overall_count)
          report_mismatch("overall_count", out_bus.data.overall_count,
                          want.overall_count);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni        = 1'b0;
    in_bus.valid  = 1'b0;
    in_bus.data   = '0;
    out_bus.ready = 1'b0;
    for (int k = 0; k < NumClasses; k++) class_stats[k] = StatReset;
    overall_stats = StatReset;

    // The block sweeps its class table after reset; the first item simply
    // waits on ready until the sweep is over.
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[r])
      send_event(directed_rows[r].stim, directed_rows[r].has_result,
                 directed_rows[r].result);

    for (int n = 0; n < RandomItems; n++) begin
      steady = (n >= SteadyFirst) && (n < SteadyLast);
      send_event(random_event(), 1'b0, '0);
    end
    steady = 1'b0;
    in_bus.valid <= 1'b0;

    // Let the last results out, then watch a little longer for strays.
    wait (pending_results.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d events (%0d counted) and scored %0d results in %0d cycles.",
             items_sent, events_counted, results_seen, cycle_count);
    $display("Mismatches found: %0d", mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/lmmat_pkg.sv
rtl/core/lmmat_if.sv
rtl/core/lmmat_ram.sv
rtl/core/lmmat_div.sv
rtl/core/latency_min_max_average_table_unit.sv
tb/sv/latency_min_max_average_table_unit_tb.sv
